FILE: design/crlf_command_line_hash_matcher_defines.svh
// ----------------------------------------------------------------------------
// CRLF command line hash matcher: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CRLF_COMMAND_LINE_HASH_MATCHER_DEFINES_SVH
`define CRLF_COMMAND_LINE_HASH_MATCHER_DEFINES_SVH

// cond must hold at every clock edge outside reset
`define CLHM_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("clhm assertion failed");

// ante implies cons at the same clock edge
`define CLHM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("clhm assertion failed");

`endif

FILE: design/clhm_pkg.sv
// ----------------------------------------------------------------------------
// CRLF command line hash matcher package
// Sizes, byte codes, status codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package clhm_pkg;

    localparam int LINE_BYTES        = 256;
    localparam int MAX_PARAMS        = 8;
    localparam int SHORT_TOKEN_LIMIT = 32;
    localparam int MAX_COMMANDS      = 7;

    localparam int LINE_CNT_W  = $clog2(LINE_BYTES + 1);
    localparam int TOK_LEN_W   = $clog2(SHORT_TOKEN_LIMIT + 1);
    localparam int PARAM_CNT_W = 4;
    localparam int HASH_W      = 32;
    localparam int CMD_IDX_W   = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CMD_SEL_W   = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;

    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_HASH_0 = 3'd1;

    typedef enum logic [2:0] {
        ST_TAKEN    = 3'd0,
        ST_MATCH    = 3'd1,
        ST_NOMATCH  = 3'd2,
        ST_CR_ERR   = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef struct packed {
        logic                   line_done;
        logic                   cr_err;
        logic                   overflow;
        logic [PARAM_CNT_W-1:0] param_count;
        logic                   long_seen;
        logic [HASH_W-1:0]      first_hash;
    } t_line_event;

    typedef struct packed {
        t_status                status;
        logic [CMD_IDX_W-1:0]   command_index;
        logic [PARAM_CNT_W-1:0] param_count;
        logic                   long_token_seen;
        logic [HASH_W-1:0]      first_token_hash;
    } t_result;

endpackage

FILE: design/clhm_line_tracker.sv
// ----------------------------------------------------------------------------
// CRLF command line hash matcher: line tracker
// Frames lines, splits tokens and keeps the running hash of the first token.
// ----------------------------------------------------------------------------
module clhm_line_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output clhm_pkg::t_line_event o_event
);
    import clhm_pkg::*;

    logic                   r_awaiting_lf, n_awaiting_lf;
    logic [LINE_CNT_W-1:0]  r_line_bytes, n_line_bytes;
    logic                   r_content_ended, n_content_ended;
    logic [TOK_LEN_W-1:0]   r_token_length, n_token_length;
    logic [HASH_W-1:0]      r_token_hash, n_token_hash;
    logic [PARAM_CNT_W-1:0] r_short_tokens, n_short_tokens;
    logic [HASH_W-1:0]      r_first_hash, n_first_hash;
    logic                   r_long_seen, n_long_seen;

    // state after closing the token in progress
    logic [PARAM_CNT_W-1:0] cl_short_tokens;
    logic [HASH_W-1:0]      cl_first_hash;
    logic                   cl_long_seen;

    always_comb begin
        cl_short_tokens = r_short_tokens;
        cl_first_hash   = r_first_hash;
        cl_long_seen    = r_long_seen;
        if (r_token_length != '0 && r_short_tokens < PARAM_CNT_W'(MAX_PARAMS)) begin
            if (r_token_length < TOK_LEN_W'(SHORT_TOKEN_LIMIT)) begin
                if (r_short_tokens == '0) begin
                    cl_first_hash = r_token_hash;
                end
                cl_short_tokens = r_short_tokens + 1'b1;
            end else begin
                cl_long_seen = 1'b1;
            end
        end
    end

    always_comb begin
        o_event         = '0;
        n_awaiting_lf   = r_awaiting_lf;
        n_line_bytes    = r_line_bytes;
        n_content_ended = r_content_ended;
        n_token_length  = r_token_length;
        n_token_hash    = r_token_hash;
        n_short_tokens  = r_short_tokens;
        n_first_hash    = r_first_hash;
        n_long_seen     = r_long_seen;

        if (r_awaiting_lf || i_byte == BYTE_LF
                || (i_byte != BYTE_CR && r_line_bytes >= LINE_CNT_W'(LINE_BYTES))) begin
            if (r_awaiting_lf) begin
                if (i_byte == BYTE_LF) begin
                    o_event.line_done   = 1'b1;
                    o_event.param_count = cl_short_tokens;
                    o_event.long_seen   = cl_long_seen;
                    o_event.first_hash  = cl_first_hash;
                end else begin
                    o_event.cr_err = 1'b1;
                end
            end else if (i_byte != BYTE_LF) begin
                o_event.overflow = 1'b1;
            end
            n_awaiting_lf   = 1'b0;
            n_line_bytes    = '0;
            n_content_ended = 1'b0;
            n_token_length  = '0;
            n_token_hash    = '0;
            n_short_tokens  = '0;
            n_first_hash    = '0;
            n_long_seen     = 1'b0;
        end else if (i_byte == BYTE_CR) begin
            n_awaiting_lf = 1'b1;
        end else begin
            n_line_bytes = r_line_bytes + 1'b1;
            if (!r_content_ended) begin
                if (i_byte == BYTE_NUL || i_byte == BYTE_SPACE) begin
                    n_short_tokens  = cl_short_tokens;
                    n_first_hash    = cl_first_hash;
                    n_long_seen     = cl_long_seen;
                    n_token_length  = '0;
                    n_token_hash    = '0;
                    n_content_ended = (i_byte == BYTE_NUL);
                end else begin
                    if (r_token_length < TOK_LEN_W'(SHORT_TOKEN_LIMIT)) begin
                        n_token_length = r_token_length + 1'b1;
                    end
                    // h * 31 + c
                    n_token_hash = (r_token_hash << 5) - r_token_hash
                                 + {{(HASH_W-8){1'b0}}, i_byte};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting_lf   <= 1'b0;
            r_line_bytes    <= '0;
            r_content_ended <= 1'b0;
            r_token_length  <= '0;
            r_token_hash    <= '0;
            r_short_tokens  <= '0;
            r_first_hash    <= '0;
            r_long_seen     <= 1'b0;
        end else if (i_step) begin
            r_awaiting_lf   <= n_awaiting_lf;
            r_line_bytes    <= n_line_bytes;
            r_content_ended <= n_content_ended;
            r_token_length  <= n_token_length;
            r_token_hash    <= n_token_hash;
            r_short_tokens  <= n_short_tokens;
            r_first_hash    <= n_first_hash;
            r_long_seen     <= n_long_seen;
        end
    end

endmodule

FILE: design/clhm_cmd_match.sv
// ----------------------------------------------------------------------------
// CRLF command line hash matcher: command table and compare
// Holds the registered command hashes and forms the result of each byte.
// ----------------------------------------------------------------------------
module clhm_cmd_match (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [clhm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [clhm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  clhm_pkg::t_line_event             i_event,
    output clhm_pkg::t_result                 o_result
);
    import clhm_pkg::*;

    logic [CMD_IDX_W-1:0] r_command_count;
    logic [HASH_W-1:0]    r_cmd_hash [MAX_COMMANDS];

    logic [CFG_IDX_W-1:0] cfg_slot;
    logic [CMD_IDX_W-1:0] cmd_limit;
    logic                 hit;
    logic [CMD_IDX_W-1:0] hit_index;

    assign cfg_slot = i_cfg_index - CFG_COMMAND_HASH_0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command_count <= '0;
            for (int i = 0; i < MAX_COMMANDS; i++) begin
                r_cmd_hash[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_COMMAND_COUNT) begin
                r_command_count <= i_cfg_data[CMD_IDX_W-1:0];
            end else if (cfg_slot < CFG_IDX_W'(MAX_COMMANDS)) begin
                r_cmd_hash[CMD_SEL_W'(cfg_slot)] <= i_cfg_data[HASH_W-1:0];
            end
        end
    end

    assign cmd_limit = (r_command_count > CMD_IDX_W'(MAX_COMMANDS))
                     ? CMD_IDX_W'(MAX_COMMANDS) : r_command_count;

    // lowest matching entry wins
    always_comb begin
        hit       = 1'b0;
        hit_index = '0;
        for (int i = MAX_COMMANDS - 1; i >= 0; i--) begin
            if (CMD_IDX_W'(i) < cmd_limit && r_cmd_hash[i] == i_event.first_hash) begin
                hit       = 1'b1;
                hit_index = CMD_IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_result = '0;
        o_result.status = ST_TAKEN;
        if (i_event.line_done) begin
            o_result.param_count      = i_event.param_count;
            o_result.long_token_seen  = i_event.long_seen;
            o_result.first_token_hash = i_event.first_hash;
            if (hit && i_event.param_count != '0) begin
                o_result.status        = ST_MATCH;
                o_result.command_index = hit_index;
            end else begin
                o_result.status = ST_NOMATCH;
            end
        end else if (i_event.cr_err) begin
            o_result.status = ST_CR_ERR;
        end else if (i_event.overflow) begin
            o_result.status = ST_OVERFLOW;
        end
    end

endmodule

FILE: design/crlf_command_line_hash_matcher.sv
// ----------------------------------------------------------------------------
// CRLF command line hash matcher
// Takes one byte per transaction and gives one result per byte. It accepts a
// byte every cycle while the input is not stalled. Each byte is held in the
// input register and its result in the result register, with the line-state
// update and the parallel compare against the command hashes between them.
// The input stalls only when both registers hold a transaction and the
// waiting result is not taken.
// ----------------------------------------------------------------------------
module crlf_command_line_hash_matcher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [clhm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [clhm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_rx_valid,
    output logic                              o_rx_ready,
    input  logic [7:0]                        i_rx_byte,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic [2:0]                        o_status,
    output logic [clhm_pkg::CMD_IDX_W-1:0]    o_command_index,
    output logic [clhm_pkg::PARAM_CNT_W-1:0]  o_param_count,
    output logic                              o_long_token_seen,
    output logic signed [clhm_pkg::HASH_W-1:0] o_first_token_hash
);
    import clhm_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_result;

    logic        advance;
    t_line_event line_event;
    t_result     result;

    assign advance    = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || advance;

    clhm_line_tracker u_line_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_event (line_event)
    );

    clhm_cmd_match u_cmd_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_event     (line_event),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_res_valid        = r_out_valid;
    assign o_status           = r_result.status;
    assign o_command_index    = r_result.command_index;
    assign o_param_count      = r_result.param_count;
    assign o_long_token_seen  = r_result.long_token_seen;
    assign o_first_token_hash = $signed(r_result.first_token_hash);

endmodule

FILE: design/clhm_checker.sv
// ----------------------------------------------------------------------------
// CRLF command line hash matcher: port checker
// Watches the result channel and checks that result fields stay consistent.
// ----------------------------------------------------------------------------
`include "crlf_command_line_hash_matcher_defines.svh"

module clhm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_res_valid,
    input logic                              i_res_ready,
    input logic [2:0]                        i_status,
    input logic [clhm_pkg::CMD_IDX_W-1:0]    i_command_index,
    input logic [clhm_pkg::PARAM_CNT_W-1:0]  i_param_count,
    input logic                              i_long_token_seen,
    input logic [clhm_pkg::HASH_W-1:0]       i_first_token_hash
);
    import clhm_pkg::*;

    logic line_end;

    assign line_end = (i_status == ST_MATCH) || (i_status == ST_NOMATCH);

    `CLHM_ASSERT_IMPL(a_stall_hold, i_clk, i_rst_n,
        $past(i_rst_n) && $past(i_res_valid) && !$past(i_res_ready),
        i_res_valid && $stable(i_status) && $stable(i_first_token_hash))
    `CLHM_ASSERT_IMPL(a_index_only_on_match, i_clk, i_rst_n,
        i_res_valid && i_status != ST_MATCH, i_command_index == '0)
    `CLHM_ASSERT_IMPL(a_line_fields_zero, i_clk, i_rst_n, i_res_valid && !line_end,
        i_param_count == '0 && !i_long_token_seen && i_first_token_hash == '0)
    `CLHM_ASSERT_IMPL(a_match_has_token, i_clk, i_rst_n,
        i_res_valid && i_status == ST_MATCH, i_param_count != '0)
    `CLHM_ASSERT_IMPL(a_param_bound, i_clk, i_rst_n,
        i_res_valid, i_param_count <= PARAM_CNT_W'(MAX_PARAMS))

endmodule

bind crlf_command_line_hash_matcher clhm_checker u_clhm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_res_valid        (o_res_valid),
    .i_res_ready        (i_res_ready),
    .i_status           (o_status),
    .i_command_index    (o_command_index),
    .i_param_count      (o_param_count),
    .i_long_token_seen  (o_long_token_seen),
    .i_first_token_hash (o_first_token_hash)
);

FILE: verif/crlf_command_line_hash_matcher_checker.sv
// ----------------------------------------------------------------------------
// CRLF command line hash matcher checker
// Watches the register port and both channels, tracks line framing, token
// counts and the first-token hash for every byte taken, and compares each
// result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module crlf_command_line_hash_matcher_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [clhm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [clhm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_rx_valid,
    input  logic                             i_rx_ready,
    input  logic [7:0]                       i_rx_byte,
    input  logic                             i_res_valid,
    input  logic                             i_res_ready,
    input  logic [2:0]                       i_status,
    input  logic [clhm_pkg::CMD_IDX_W-1:0]   i_command_index,
    input  logic [clhm_pkg::PARAM_CNT_W-1:0] i_param_count,
    input  logic                             i_long_token_seen,
    input  logic [clhm_pkg::HASH_W-1:0]      i_first_token_hash,
    output int                               o_fail_count,
    output int                               o_pending
);
    import clhm_pkg::*;

    logic                   cr_seen;
    logic [LINE_CNT_W-1:0]  line_len;
    logic                   text_done;
    logic [TOK_LEN_W-1:0]   tok_len;
    logic [HASH_W-1:0]      tok_hash;
    logic [PARAM_CNT_W-1:0] param_total;
    logic [HASH_W-1:0]      lead_hash;
    logic                   long_flag;

    logic [2:0]             cmd_count;
    logic [HASH_W-1:0]      cmd_hash [MAX_COMMANDS];

    t_result                line_results [$];
    t_result                want;
    int                     fail_total;

    task automatic clear_line();
        cr_seen     = 1'b0;
        line_len    = '0;
        text_done   = 1'b0;
        tok_len     = '0;
        tok_hash    = '0;
        param_total = '0;
        lead_hash   = '0;
        long_flag   = 1'b0;
    endtask

    task automatic finish_token();
        if (tok_len != 0 && param_total < MAX_PARAMS) begin
            if (tok_len < SHORT_TOKEN_LIMIT) begin
                if (param_total == 0)
                    lead_hash = tok_hash;
                param_total++;
            end else begin
                long_flag = 1'b1;
            end
        end
        tok_len  = '0;
        tok_hash = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, output t_result r);
        bit hit;
        r   = '0;
        hit = 1'b0;
        if (cr_seen) begin
            if (b == BYTE_LF) begin
                finish_token();
                r.status           = ST_NOMATCH;
                r.param_count      = param_total;
                r.long_token_seen  = long_flag;
                r.first_token_hash = lead_hash;
                if (param_total != 0) begin
                    for (int i = 0; i < MAX_COMMANDS; i++) begin
                        if (!hit && i < cmd_count && cmd_hash[i] == lead_hash) begin
                            hit             = 1'b1;
                            r.status        = ST_MATCH;
                            r.command_index = CMD_IDX_W'(i);
                        end
                    end
                end
            end else begin
                r.status = ST_CR_ERR;
            end
            clear_line();
        end else if (b == BYTE_CR) begin
            cr_seen = 1'b1;
        end else if (b == BYTE_LF) begin
            clear_line();
        end else if (line_len >= LINE_BYTES) begin
            r.status = ST_OVERFLOW;
            clear_line();
        end else begin
            line_len++;
            if (!text_done) begin
                if (b == BYTE_NUL) begin
                    finish_token();
                    text_done = 1'b1;
                end else if (b == BYTE_SPACE) begin
                    finish_token();
                end else begin
                    if (tok_len < SHORT_TOKEN_LIMIT)
                        tok_len++;
                    tok_hash = tok_hash * 32'd31 + {24'd0, b};
                end
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, act_val);
            fail_total++;
        end
    endtask

    initial fail_total = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
            cmd_count = '0;
            for (int i = 0; i < MAX_COMMANDS; i++)
                cmd_hash[i] = '0;
            line_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_COMMAND_COUNT)
                    cmd_count = i_cfg_data[2:0];
                else
                    cmd_hash[i_cfg_index - CFG_COMMAND_HASH_0] = i_cfg_data;
            end
            if (i_res_valid && i_res_ready) begin
                if (line_results.size() == 0) begin
                    $display("%0t: result transaction with none expected, status %0d",
                             $time, i_status);
                    fail_total++;
                end else begin
                    want = line_results.pop_front();
                    compare_field("status", want.status, i_status);
                    compare_field("command_index", want.command_index, i_command_index);
                    compare_field("param_count", want.param_count, i_param_count);
                    compare_field("long_token_seen", want.long_token_seen,
                                  i_long_token_seen);
                    compare_field("first_token_hash", want.first_token_hash,
                                  i_first_token_hash);
                end
            end
            if (i_rx_valid && i_rx_ready) begin
                parse_byte(i_rx_byte, want);
                line_results.push_back(want);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= line_results.size();
    end

endmodule

FILE: verif/crlf_command_line_hash_matcher_test.sv
// ----------------------------------------------------------------------------
// CRLF command line hash matcher testbench
// Loads several sets of command hashes, then sends short directed lines and
// a long run of random command lines, noise, broken CR, bare LF and
// overflowing lines with random gaps on both channels. The checker module
// predicts and compares; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module crlf_command_line_hash_matcher_test;
    import clhm_pkg::*;

    localparam int PHASES       = 4;
    localparam int PHASE_ITEMS  = 275;
    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 150;
    localparam int SIDE_RX      = 0;
    localparam int SIDE_RES     = 1;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   rx_valid;
    logic                   rx_ready;
    logic [7:0]             rx_byte;
    logic                   res_valid;
    logic                   res_ready;
    logic [2:0]             status;
    logic [CMD_IDX_W-1:0]   command_index;
    logic [PARAM_CNT_W-1:0] param_count;
    logic                   long_token_seen;
    logic [HASH_W-1:0]      first_token_hash;

    int                     fail_count;
    int                     pending;
    int                     sent_count;
    int                     stretch_left [2];
    int                     stretch_mode [2];
    logic [7:0]             line_q [$];

    string command_names [8] = '{"go", "help", "ls", "reset", "status", "x",
                                 "version", "led"};

    crlf_command_line_hash_matcher dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_rx_valid         (rx_valid),
        .o_rx_ready         (rx_ready),
        .i_rx_byte          (rx_byte),
        .o_res_valid        (res_valid),
        .i_res_ready        (res_ready),
        .o_status           (status),
        .o_command_index    (command_index),
        .o_param_count      (param_count),
        .o_long_token_seen  (long_token_seen),
        .o_first_token_hash (first_token_hash)
    );

    crlf_command_line_hash_matcher_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_rx_valid         (rx_valid),
        .i_rx_ready         (rx_ready),
        .i_rx_byte          (rx_byte),
        .i_res_valid        (res_valid),
        .i_res_ready        (res_ready),
        .i_status           (status),
        .i_command_index    (command_index),
        .i_param_count      (param_count),
        .i_long_token_seen  (long_token_seen),
        .i_first_token_hash (first_token_hash),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // idle pattern changes every few dozen transactions: none, sparse, heavy
    function automatic int pick_gap(int side);
        if (stretch_left[side] == 0) begin
            stretch_mode[side] = $urandom_range(0, 2);
            stretch_left[side] = $urandom_range(20, 80);
        end
        stretch_left[side]--;
        case (stretch_mode[side])
            0:       return 0;
            1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
            default: return $urandom_range(0, 13);
        endcase
    endfunction

    function automatic logic [HASH_W-1:0] text_hash(input string s);
        logic [HASH_W-1:0] h;
        logic [7:0]        c;
        h = '0;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            h = h * 32'd31 + {24'd0, c};
        end
        return h;
    endfunction

    function automatic logic [7:0] token_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(33, 126));
        do
            c = 8'($urandom_range(1, 255));
        while (c == BYTE_LF || c == BYTE_CR || c == BYTE_SPACE);
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(SIDE_RX);
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!(rx_valid && rx_ready));
        sent_count++;
    endtask

    task automatic send_queued();
        foreach (line_q[i])
            send_byte(line_q[i]);
        line_q.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    task automatic push_crlf();
        line_q.push_back(BYTE_CR);
        line_q.push_back(BYTE_LF);
    endtask

    task automatic add_token(input int len);
        repeat (len) line_q.push_back(token_char());
    endtask

    task automatic wait_drained();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_commands(input int phase);
        logic [HASH_W-1:0] hashes [MAX_COMMANDS];
        logic [2:0]        count;
        case (phase)
            0: begin
                count = 3'd7;
                for (int i = 0; i < 6; i++)
                    hashes[i] = text_hash(command_names[i]);
                hashes[6] = text_hash(command_names[0]);
            end
            1: begin
                // names loaded but count zero: nothing may match
                count     = 3'd0;
                hashes[0] = 32'h8000_0000;
                hashes[1] = 32'h7FFF_FFFF;
                hashes[2] = 32'h0000_0000;
                hashes[3] = 32'hFFFF_FFFF;
                for (int i = 4; i < MAX_COMMANDS; i++)
                    hashes[i] = text_hash(command_names[i - 4]);
            end
            2: begin
                count = 3'($urandom_range(1, 6));
                for (int i = 0; i < MAX_COMMANDS; i++)
                    hashes[i] = ($urandom_range(0, 1) != 0) ?
                                text_hash(command_names[$urandom_range(0, 7)]) : $urandom();
            end
            default: begin
                // zero hash registered: empty lines must still be unmatched
                count     = 3'd7;
                hashes[0] = 32'h0000_0000;
                hashes[1] = 32'h8000_0000;
                for (int i = 2; i < MAX_COMMANDS; i++)
                    hashes[i] = text_hash(command_names[7 - i]);
            end
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COMMAND_COUNT;
        cfg_data  <= {29'($urandom()), count};
        @(posedge clk);
        for (int i = 0; i < MAX_COMMANDS; i++) begin
            cfg_index <= CFG_COMMAND_HASH_0 + CFG_IDX_W'(i);
            cfg_data  <= hashes[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic directed_lines();
        push_text("go");
        push_crlf();
        line_q.push_back(8'hFF);
        line_q.push_back(BYTE_NUL);
        push_text("a");
        push_crlf();
        push_text("q");
        line_q.push_back(BYTE_LF);
        line_q.push_back(BYTE_CR);
        push_text("z");
        push_crlf();
        line_q.push_back(BYTE_CR);
        line_q.push_back(BYTE_CR);
        push_text("ls  x");
        push_crlf();
        send_queued();
    endtask

    task automatic random_line(input bit force_overflow);
        int         kind;
        int         len;
        int         pick;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (force_overflow || kind == 99) begin
            len = force_overflow ? $urandom_range(257, 258) : $urandom_range(255, 258);
            while (line_q.size() < len)
                line_q.push_back(($urandom_range(0, 7) == 0) ? BYTE_SPACE : token_char());
            push_crlf();
        end else if (kind < 10) begin
            repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) line_q.push_back(BYTE_SPACE);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: push_text(command_names[$urandom_range(0, 7)]);
                6, 7:             add_token($urandom_range(1, 6));
                8:                add_token($urandom_range(31, 40));
                default:          ;
            endcase
            repeat ($urandom_range(0, 11)) begin
                repeat ($urandom_range(1, 2)) line_q.push_back(BYTE_SPACE);
                pick = $urandom_range(0, 19);
                len  = (pick < 17) ? $urandom_range(1, 6) :
                       (pick < 19) ? $urandom_range(30, 33) : $urandom_range(34, 45);
                add_token(len);
                if ($urandom_range(0, 24) == 0)
                    line_q.push_back(BYTE_NUL);
            end
            if ($urandom_range(0, 3) == 0)
                line_q.push_back(BYTE_SPACE);
            if (kind < 20) begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == BYTE_LF);
                line_q.push_back(BYTE_CR);
                line_q.push_back(c);
            end else if (kind < 27) begin
                line_q.push_back(BYTE_LF);
            end else begin
                push_crlf();
            end
        end
        send_queued();
    endtask

    initial begin : stimulus
        int line_no;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_COMMAND_COUNT;
        cfg_data   <= '0;
        rx_valid   <= 1'b0;
        rx_byte    <= '0;
        sent_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < PHASES; phase++) begin
            load_commands(phase);
            if (phase == 0)
                directed_lines();
            line_no = 0;
            while (sent_count < (phase + 1) * PHASE_ITEMS) begin
                random_line(phase % 2 == 1 && line_no == 4);
                line_no++;
            end
            wait_drained();
        end
        if (fail_count == 0 && pending == 0)
            $display("crlf_command_line_hash_matcher_test passed");
        else
            $display("crlf_command_line_hash_matcher_test failed");
        $finish;
    end

    initial begin : result_sink
        int gap;
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        res_ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever begin
            // one long hold-off lets the block fill up and stall its input
            if (!held && taken == HOLD_AT) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end else begin
                gap = pick_gap(SIDE_RES);
            end
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(res_valid && res_ready));
            taken++;
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || (rx_valid && rx_ready) || (res_valid && res_ready))
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT) begin
                $display("crlf_command_line_hash_matcher_test failed");
                $finish;
            end
        end
    end

endmodule
